>>> hdl/sbct_pkg.sv
package sbct_pkg;

   localparam int SECTOR_WIDTH = 32;
   localparam int INDEX_WIDTH  = 8;
   localparam int SLOT_WIDTH   = 2;
   localparam int LOG2_WIDTH   = 3;

   localparam logic [LOG2_WIDTH-1:0] LOG2_MAX   = 3'd6;
   localparam logic [LOG2_WIDTH-1:0] LOG2_RESET = 3'd6;

   // victim search starts from this score and uses strict less-than
   localparam logic signed [SECTOR_WIDTH:0] PICK_THRESHOLD = 33'sh0_0FFF_FFFF;

   localparam logic signed [2:0] SCORE_BONUS = 3'sd2;
   localparam logic signed [2:0] SCORE_DECAY = -3'sd1;

   typedef struct packed {
      logic                    hit;
      logic [INDEX_WIDTH-1:0]  buffer_index;
      logic [SLOT_WIDTH-1:0]   fill_slot;
      logic [SECTOR_WIDTH-1:0] fill_sector;
   } sbct_rsp_type;

endpackage

>>> hdl/sbct_dir.sv
module sbct_dir #(
   parameter int ENTRIES     = 4,
   parameter int SCORE_WIDTH = 16
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             lookup_en,
   input  logic [sbct_pkg::SECTOR_WIDTH-1:0] sector,
   input  logic [sbct_pkg::LOG2_WIDTH-1:0]   blk_log2,
   output sbct_pkg::sbct_rsp_type            result
);
   import sbct_pkg::*;

   localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int EXT_W = SCORE_WIDTH + 2;

   localparam logic signed [EXT_W-1:0] SCORE_HI = {3'b000, {(SCORE_WIDTH-1){1'b1}}};
   localparam logic signed [EXT_W-1:0] SCORE_LO = {3'b111, {(SCORE_WIDTH-1){1'b0}}};

   typedef logic signed [SCORE_WIDTH-1:0] score_type;

   function automatic score_type sat_add(score_type s, logic signed [2:0] d);
      logic signed [EXT_W-1:0] sum;
      sum = EXT_W'(s) + EXT_W'(d);
      if (sum > SCORE_HI) begin
         sat_add = SCORE_HI[SCORE_WIDTH-1:0];
      end else if (sum < SCORE_LO) begin
         sat_add = SCORE_LO[SCORE_WIDTH-1:0];
      end else begin
         sat_add = sum[SCORE_WIDTH-1:0];
      end
   endfunction

   logic [SECTOR_WIDTH-1:0] base_ff  [ENTRIES];
   logic [SECTOR_WIDTH-1:0] base_in  [ENTRIES];
   logic [ENTRIES-1:0]      valid_ff;
   logic [ENTRIES-1:0]      valid_in;
   score_type               score_ff  [ENTRIES];
   score_type               score_in  [ENTRIES];
   score_type               score_dec [ENTRIES];

   logic [SECTOR_WIDTH:0]     diff [ENTRIES];
   logic [ENTRIES-1:0]        match;
   logic [LOG2_WIDTH-1:0]     lg;
   logic [SECTOR_WIDTH-1:0]   mask;
   logic [SECTOR_WIDTH-1:0]   aligned;
   logic [IDX_W-1:0]          found;
   logic [IDX_W-1:0]          pick;
   logic                      hit;
   logic [SECTOR_WIDTH-1:0]   index_full;

   // per-entry cover test and score aging
   always_comb begin
      score_type bump;
      lg      = (blk_log2 > LOG2_MAX) ? LOG2_MAX : blk_log2;
      mask    = (SECTOR_WIDTH'(1) << lg) - SECTOR_WIDTH'(1);
      aligned = sector & ~mask;
      for (int i = 0; i < ENTRIES; i++) begin
         // borrow bit set means sector below base
         diff[i]  = {1'b0, sector} - {1'b0, base_ff[i]};
         match[i] = valid_ff[i] && !diff[i][SECTOR_WIDTH] &&
                    ((diff[i][SECTOR_WIDTH-1:0] & ~mask) == '0);
         bump = score_ff[i];
         if (match[i]) begin
            if (bump[SCORE_WIDTH-1]) begin
               bump = '0;
            end
            bump = sat_add(bump, SCORE_BONUS);
         end
         score_dec[i] = sat_add(bump, SCORE_DECAY);
      end
   end

   // last match wins, first lowest score is the victim
   always_comb begin
      logic signed [SECTOR_WIDTH:0] best;
      logic signed [SECTOR_WIDTH:0] cand;
      found = '0;
      pick  = '0;
      best  = PICK_THRESHOLD;
      for (int i = 0; i < ENTRIES; i++) begin
         if (match[i]) begin
            found = IDX_W'(i);
         end
         cand = (SECTOR_WIDTH+1)'(score_dec[i]);
         if (cand < best) begin
            best = cand;
            pick = IDX_W'(i);
         end
      end
      hit = |match;
   end

   always_comb begin
      base_in  = base_ff;
      valid_in = valid_ff;
      score_in = score_ff;
      if (lookup_en) begin
         score_in = score_dec;
         if (!hit) begin
            score_in[pick] = sat_add(score_dec[pick], SCORE_BONUS);
            base_in[pick]  = aligned;
            valid_in[pick] = 1'b1;
         end
      end
   end

   always_comb begin
      if (hit) begin
         index_full = (SECTOR_WIDTH'(found) << lg) + diff[found][SECTOR_WIDTH-1:0];
      end else begin
         index_full = (SECTOR_WIDTH'(pick) << lg) + (sector & mask);
      end
      result.hit          = hit;
      result.buffer_index = index_full[INDEX_WIDTH-1:0];
      result.fill_slot    = hit ? '0 : SLOT_WIDTH'(SECTOR_WIDTH'(pick));
      result.fill_sector  = hit ? '0 : aligned;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         score_ff <= '{default: '0};
      end else begin
         valid_ff <= valid_in;
         score_ff <= score_in;
      end
   end

   always_ff @(posedge clock) begin
      base_ff <= base_in;
   end

endmodule

>>> hdl/sector_block_cache_tax_replace.sv
// sector block cache directory with usage-score replacement
//
// req channel carries one sector number per request; rsp channel returns one
// result per request: hit flag, buffer sector index and, on a miss, the slot
// and aligned first sector of the block to fill. csr_write_en loads the
// block size register (log2 of sectors per block, values above 6 act as 6).
// Write it only while no request is in flight.
//
// a request passes an input register, then directory lookup and score update
// into the result register, which drives rsp_valid. one request is taken every
// cycle while req_stall is low. the score update of one request is registered
// and feeds the lookup of the next.
//
// reset clears all entries to invalid, all scores to zero and the block size
// to 6. when rsp_stall is high the result holds and the input register takes
// one more request, after which req_stall rises until the result is taken.
module sector_block_cache_tax_replace #(
   parameter int ENTRIES     = 4,
   parameter int SCORE_WIDTH = 16
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic [sbct_pkg::SECTOR_WIDTH-1:0]  req_sector,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic                               rsp_hit,
   output logic [sbct_pkg::INDEX_WIDTH-1:0]   rsp_buffer_index,
   output logic [sbct_pkg::SLOT_WIDTH-1:0]    rsp_fill_slot,
   output logic [sbct_pkg::SECTOR_WIDTH-1:0]  rsp_fill_sector,
   input  logic                               csr_write_en,
   input  logic [sbct_pkg::LOG2_WIDTH-1:0]    csr_write_data
);
   import sbct_pkg::*;

   logic                    req_full_ff, req_full_in;
   logic [SECTOR_WIDTH-1:0] sector_ff, sector_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   sbct_rsp_type            rsp_ff, rsp_in;
   logic [LOG2_WIDTH-1:0]   blk_log2_ff, blk_log2_in;

   logic         out_free;
   logic         fire;
   logic         accept;
   sbct_rsp_type result;

   sbct_dir #(
      .ENTRIES     (ENTRIES),
      .SCORE_WIDTH (SCORE_WIDTH)
   ) u_dir (
      .clock     (clock),
      .reset     (reset),
      .lookup_en (fire),
      .sector    (sector_ff),
      .blk_log2  (blk_log2_ff),
      .result    (result)
   );

   always_comb begin
      out_free  = !rsp_valid_ff || !rsp_stall;
      fire      = req_full_ff && out_free;
      req_stall = req_full_ff && !out_free;
      accept    = req_valid && !req_stall;

      req_full_in = req_full_ff;
      if (accept) begin
         req_full_in = 1'b1;
      end else if (fire) begin
         req_full_in = 1'b0;
      end
      sector_in = accept ? req_sector : sector_ff;

      rsp_valid_in = rsp_valid_ff;
      if (fire) begin
         rsp_valid_in = 1'b1;
      end else if (out_free) begin
         rsp_valid_in = 1'b0;
      end
      rsp_in = fire ? result : rsp_ff;

      blk_log2_in = csr_write_en ? csr_write_data : blk_log2_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         req_full_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         blk_log2_ff  <= LOG2_RESET;
      end else begin
         req_full_ff  <= req_full_in;
         rsp_valid_ff <= rsp_valid_in;
         blk_log2_ff  <= blk_log2_in;
      end
   end

   always_ff @(posedge clock) begin
      sector_ff <= sector_in;
      rsp_ff    <= rsp_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_hit          = rsp_ff.hit;
   assign rsp_buffer_index = rsp_ff.buffer_index;
   assign rsp_fill_slot    = rsp_ff.fill_slot;
   assign rsp_fill_sector  = rsp_ff.fill_sector;

endmodule
